@@ sv/grc_pkg.sv @@
// shared constants, codes and control structs of the column ray caster
package grc_pkg;

    localparam int MAP_SIZE_DEF      = 64;
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;
    localparam int MAX_STEPS_DEF     = 100;

    localparam int DIV_NW     = 31;
    localparam int DIV_DW     = 24;
    localparam int CELL_W     = 4;
    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X   = 3'd0,
        CFG_POS_Y   = 3'd1,
        CFG_DIR_X   = 3'd2,
        CFG_DIR_Y   = 3'd3,
        CFG_PLANE_X = 3'd4,
        CFG_PLANE_Y = 3'd5,
        CFG_EYE     = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_DX  = 2'd0,
        DIV_DY  = 2'd1,
        DIV_HGT = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     map_wr;
        logic     clr_wr;
        logic     div_go;
        div_sel_t div_sel;
        logic     cam_set;
        logic     ray_x;
        logic     ray_y;
        logic     dx_set;
        logic     dy_set;
        logic     side_x;
        logic     side_y;
        logic     step;
        logic     test;
        logic     h_set;
        logic     tex;
        logic     finish;
    } grc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic hit_now;
    } grc_status_t;

endpackage

@@ sv/grc_ram.sv @@
// generic single write port ram with registered read
module grc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/grc_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
module grc_div #(
    parameter int NW = 31,
    parameter int DW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = DW'(trial - {1'b0, den_reg});
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ sv/grc_dp.sv @@
// datapath: config registers, map ram, divider, ray set-up, dda walk and result registers
module grc_dp #(
    parameter int MAP_SIZE      = 64,
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_STEPS     = 100
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  grc_pkg::grc_cmd_t                  cmd,
    output grc_pkg::grc_status_t               status,
    input  logic                               cfg_valid,
    input  logic [grc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [9:0]                         column,
    input  logic [5:0]                         cell_x,
    input  logic [5:0]                         cell_y,
    input  logic [3:0]                         cell_kind,
    output logic                               done,
    output logic [9:0]                         column_out,
    output logic                               hit,
    output logic                               side,
    output logic [3:0]                         wall_kind,
    output logic [15:0]                        perp_dist,
    output logic signed [10:0]                 wall_top,
    output logic signed [10:0]                 wall_bottom,
    output logic [11:0]                        tex_u
);

    import grc_pkg::*;

    localparam int AW     = $clog2(MAP_SIZE * MAP_SIZE);
    localparam int SIDE_W = 42 + $clog2(MAX_STEPS + 1);
    localparam logic [AW-1:0] MS       = AW'(MAP_SIZE);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAP_SIZE * MAP_SIZE - 1);
    localparam logic [40:0]   DELTA_INF = 41'h100_0000_0000;
    localparam logic [20:0]   HEIGHT_MAX = 21'h10_0000;
    localparam logic [23:0]   PERP_MAX = 24'hFF_FFFF;
    // reciprocal of the screen width, scaled by 2^40 and rounded up
    localparam logic [40:0]   CAM_MUL =
        41'(((64'd1 << 40) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    // configuration
    logic [13:0]        pos_x_reg, pos_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic signed [9:0]  eye_reg;

    // item
    logic [9:0]         column_reg;
    logic [5:0]         cx_reg, cy_reg;
    logic [3:0]         kind_reg;

    // cast
    logic signed [15:0]       cam_reg;
    logic signed [18:0]       rx_reg, ry_reg;
    logic [40:0]              dx_reg, dy_reg;
    logic [SIDE_W-1:0]        sx_reg, sy_reg;
    logic signed [COORD_W-1:0] mx_reg, my_reg;
    logic [23:0]              perp_reg;
    logic                     side_reg, hit_reg;
    logic [3:0]               wk_reg;
    logic [20:0]              h_reg;
    logic [11:0]              tex_reg;
    logic [AW-1:0]            clr_reg;

    // results
    logic                     done_reg;
    logic [9:0]               col_o_reg;
    logic                     hit_o_reg, side_o_reg;
    logic [3:0]               wk_o_reg;
    logic [15:0]              perp_o_reg;
    logic signed [10:0]       top_o_reg, bot_o_reg;
    logic [11:0]              tex_o_reg;

    // divider
    logic                     div_done;
    logic [DIV_NW-1:0]        div_num, div_quo;
    logic [DIV_DW-1:0]        div_den;

    // ram
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [3:0]               ram_wdata, ram_rdata;

    // combinational
    logic [18:0]              rx_abs, ry_abs;
    logic [50:0]              cam_prod;
    logic signed [31:0]       cam_full;
    logic signed [15:0]       cam_clamped;
    logic signed [31:0]       ray_prod;
    logic [8:0]               frac_mult;
    logic [49:0]              side_prod;
    logic                     take_x;
    logic signed [COORD_W-1:0] mx_n, my_n;
    logic [23:0]              perp_n;
    logic                     in_grid;
    logic                     wr_in_grid;
    logic signed [43:0]       tex_prod;
    logic [29:0]              wall_frac;
    logic signed [11:0]       centre;
    logic signed [22:0]       top_w, bot_w;

    function automatic logic signed [10:0] sat11(input logic signed [22:0] v);
        if (v < -23'sd1024)
        begin
            return -11'sd1024;
        end
        if (v > 23'sd1023)
        begin
            return 11'sd1023;
        end
        return v[10:0];
    endfunction

    function automatic logic [23:0] clamp_perp(input logic [SIDE_W-1:0] v);
        if (v > SIDE_W'(PERP_MAX))
        begin
            return PERP_MAX;
        end
        return v[23:0];
    endfunction

    grc_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    grc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAP_SIZE * MAP_SIZE)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rx_abs = rx_reg[18] ? 19'(-rx_reg) : 19'(rx_reg);
        ry_abs = ry_reg[18] ? 19'(-ry_reg) : 19'(ry_reg);

        case (cmd.div_sel)
            DIV_DX:
            begin
                div_num = DIV_NW'(1) << 30;
                div_den = DIV_DW'(rx_abs);
            end
            DIV_DY:
            begin
                div_num = DIV_NW'(1) << 30;
                div_den = DIV_DW'(ry_abs);
            end
            DIV_HGT:
            begin
                div_num = DIV_NW'(SCREEN_HEIGHT) << 16;
                div_den = perp_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase

        // column * 2^15 / screen width by reciprocal multiplication
        cam_prod = {41'b0, column_reg} * {10'b0, CAM_MUL};
        cam_full = $signed({6'b0, cam_prod[50:25]}) - 32'sd16384;
        if (cam_full > 32'sd32767)
        begin
            cam_clamped = 16'sh7FFF;
        end
        else if (cam_full < -32'sd32768)
        begin
            cam_clamped = -16'sh8000;
        end
        else
        begin
            cam_clamped = cam_full[15:0];
        end

        ray_prod = cmd.ray_x ? (plane_x_reg * cam_reg) : (plane_y_reg * cam_reg);

        if (cmd.side_x)
        begin
            frac_mult = rx_reg[18] ? {1'b0, pos_x_reg[7:0]} : 9'(9'd256 - pos_x_reg[7:0]);
            side_prod = {9'b0, dx_reg} * {41'b0, frac_mult};
        end
        else
        begin
            frac_mult = ry_reg[18] ? {1'b0, pos_y_reg[7:0]} : 9'(9'd256 - pos_y_reg[7:0]);
            side_prod = {9'b0, dy_reg} * {41'b0, frac_mult};
        end

        // next dda cell
        take_x = sx_reg < sy_reg;
        mx_n   = mx_reg;
        my_n   = my_reg;
        if (take_x)
        begin
            perp_n = clamp_perp(sx_reg);
            mx_n   = rx_reg[18] ? mx_reg - 1'b1 : mx_reg + 1'b1;
        end
        else
        begin
            perp_n = clamp_perp(sy_reg);
            my_n   = ry_reg[18] ? my_reg - 1'b1 : my_reg + 1'b1;
        end

        in_grid = (mx_reg >= 0) && (mx_reg < MAP_SIZE) && (my_reg >= 0) && (my_reg < MAP_SIZE);
        wr_in_grid = (32'(cx_reg) < MAP_SIZE) && (32'(cy_reg) < MAP_SIZE);

        ram_raddr = AW'(mx_n) * MS + AW'(my_n);
        ram_we    = cmd.clr_wr || (cmd.map_wr && wr_in_grid);
        ram_waddr = cmd.clr_wr ? clr_reg : AW'(cx_reg) * MS + AW'(cy_reg);
        ram_wdata = cmd.clr_wr ? '0 : kind_reg;

        tex_prod  = side_reg ? ($signed({1'b0, perp_reg}) * rx_reg)
                             : ($signed({1'b0, perp_reg}) * ry_reg);
        wall_frac = (side_reg ? {pos_x_reg[7:0], 22'b0} : {pos_y_reg[7:0], 22'b0})
                    + tex_prod[29:0];

        centre = 12'(SCREEN_HEIGHT / 2) - 12'(eye_reg);
        top_w  = 23'(centre) - $signed({3'b0, h_reg[20:1]});
        bot_w  = 23'(centre) + $signed({3'b0, h_reg[20:1]});

        status.clr_last = clr_reg == CLR_LAST;
        status.div_done = div_done;
        status.hit_now  = in_grid && (ram_rdata != '0);
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= 16'sd16384;
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= 16'sd10813;
            eye_reg     <= '0;
            clr_reg     <= '0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_POS_X:   pos_x_reg   <= cfg_data[13:0];
                    CFG_POS_Y:   pos_y_reg   <= cfg_data[13:0];
                    CFG_DIR_X:   dir_x_reg   <= cfg_data;
                    CFG_DIR_Y:   dir_y_reg   <= cfg_data;
                    CFG_PLANE_X: plane_x_reg <= cfg_data;
                    CFG_PLANE_Y: plane_y_reg <= cfg_data;
                    CFG_EYE:     eye_reg     <= cfg_data[9:0];
                    default:     ;
                endcase
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.test && status.hit_now)
            begin
                hit_reg <= 1'b1;
            end
            done_reg <= cmd.finish;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            column_reg <= column;
            cx_reg     <= cell_x;
            cy_reg     <= cell_y;
            kind_reg   <= cell_kind;
            mx_reg     <= COORD_W'(pos_x_reg[13:8]);
            my_reg     <= COORD_W'(pos_y_reg[13:8]);
            perp_reg   <= '0;
            side_reg   <= 1'b0;
        end
        if (cmd.cam_set)
        begin
            cam_reg <= cam_clamped;
        end
        if (cmd.ray_x)
        begin
            rx_reg <= 19'(dir_x_reg) + 19'($signed(ray_prod[31:14]));
        end
        if (cmd.ray_y)
        begin
            ry_reg <= 19'(dir_y_reg) + 19'($signed(ray_prod[31:14]));
        end
        if (cmd.dx_set)
        begin
            dx_reg <= (rx_reg == '0) ? DELTA_INF : 41'(div_quo);
        end
        if (cmd.dy_set)
        begin
            dy_reg <= (ry_reg == '0) ? DELTA_INF : 41'(div_quo);
        end
        if (cmd.side_x)
        begin
            sx_reg <= SIDE_W'(side_prod[49:8]);
        end
        if (cmd.side_y)
        begin
            sy_reg <= SIDE_W'(side_prod[49:8]);
        end
        if (cmd.step)
        begin
            perp_reg <= perp_n;
            mx_reg   <= mx_n;
            my_reg   <= my_n;
            side_reg <= !take_x;
            if (take_x)
            begin
                sx_reg <= sx_reg + SIDE_W'(dx_reg);
            end
            else
            begin
                sy_reg <= sy_reg + SIDE_W'(dy_reg);
            end
        end
        if (cmd.test)
        begin
            wk_reg <= ram_rdata;
        end
        if (cmd.h_set)
        begin
            if (perp_reg == '0 || div_quo > DIV_NW'(HEIGHT_MAX))
            begin
                h_reg <= HEIGHT_MAX;
            end
            else
            begin
                h_reg <= 21'(div_quo);
            end
        end
        if (cmd.tex)
        begin
            tex_reg <= wall_frac[29:18];
        end
        if (cmd.finish)
        begin
            col_o_reg <= column_reg;
            if (hit_reg)
            begin
                hit_o_reg  <= 1'b1;
                side_o_reg <= side_reg;
                wk_o_reg   <= wk_reg;
                perp_o_reg <= perp_reg[23:8];
                top_o_reg  <= sat11(top_w);
                bot_o_reg  <= sat11(bot_w);
                tex_o_reg  <= tex_reg;
            end
            else
            begin
                hit_o_reg  <= 1'b0;
                side_o_reg <= 1'b0;
                wk_o_reg   <= '0;
                perp_o_reg <= '0;
                top_o_reg  <= '0;
                bot_o_reg  <= '0;
                tex_o_reg  <= '0;
            end
        end
    end

    assign done        = done_reg;
    assign column_out  = col_o_reg;
    assign hit         = hit_o_reg;
    assign side        = side_o_reg;
    assign wall_kind   = wk_o_reg;
    assign perp_dist   = perp_o_reg;
    assign wall_top    = top_o_reg;
    assign wall_bottom = bot_o_reg;
    assign tex_u       = tex_o_reg;

endmodule

@@ sv/grc_ctrl.sv @@
// controller: map clear sweep, item sequencing and dda step loop
module grc_ctrl #(
    parameter int MAX_STEPS = 100
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 op,
    input  grc_pkg::grc_status_t status,
    output grc_pkg::grc_cmd_t    cmd,
    output logic                 busy
);

    import grc_pkg::*;

    localparam int NW = $clog2(MAX_STEPS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_CAM,
        ST_RAY_X,
        ST_RAY_Y,
        ST_DX_GO,
        ST_DX_WAIT,
        ST_DY_GO,
        ST_DY_WAIT,
        ST_SIDE_X,
        ST_SIDE_Y,
        ST_STEP,
        ST_TEST,
        ST_H_GO,
        ST_H_WAIT,
        ST_TEX,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic          busy_reg;
    logic [NW-1:0] n_reg, n_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        n_next     = n_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                n_next = '0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (op == OP_CAST) ? ST_CAM : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.map_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CAM:
            begin
                cmd.cam_set = 1'b1;
                state_next  = ST_RAY_X;
            end
            ST_RAY_X:
            begin
                cmd.ray_x  = 1'b1;
                state_next = ST_RAY_Y;
            end
            ST_RAY_Y:
            begin
                cmd.ray_y  = 1'b1;
                state_next = ST_DX_GO;
            end
            ST_DX_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_DX;
                state_next  = ST_DX_WAIT;
            end
            ST_DX_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.dx_set = 1'b1;
                    state_next = ST_DY_GO;
                end
            end
            ST_DY_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_DY;
                state_next  = ST_DY_WAIT;
            end
            ST_DY_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.dy_set = 1'b1;
                    state_next = ST_SIDE_X;
                end
            end
            ST_SIDE_X:
            begin
                cmd.side_x = 1'b1;
                state_next = ST_SIDE_Y;
            end
            ST_SIDE_Y:
            begin
                cmd.side_y = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                n_next     = n_reg + 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                cmd.test = 1'b1;
                if (status.hit_now)
                begin
                    state_next = ST_H_GO;
                end
                else if (n_reg == NW'(MAX_STEPS))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_H_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_HGT;
                state_next  = ST_H_WAIT;
            end
            ST_H_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.h_set  = 1'b1;
                    state_next = ST_TEX;
                end
            end
            ST_TEX:
            begin
                cmd.tex    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != ST_IDLE;
            n_reg     <= n_next;
        end
    end

    assign busy = busy_reg;

endmodule

@@ sv/grid_raycast_column.sv @@
// top level of the dda column ray caster over a tile map
//
//  channel   signals                                        transaction at
//  item      start, busy, op, column, cell_x/y, cell_kind   start & !busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid & cfg_ready
//  result    done, column_out .. tex_u                      done (one cycle)
//
//  after reset the map ram is swept to empty, with busy high
//  a cast runs the shared divider for the ray deltas, then up to MAX_STEPS dda steps
//  (step, map read each), the divider again for the wall height on a hit, and the
//  set-up and finish states
//  the result strobe is registered from the finish state; the receiver cannot stall it
//  configuration transactions are always taken
module grid_raycast_column #(
    parameter int MAP_SIZE      = grc_pkg::MAP_SIZE_DEF,
    parameter int SCREEN_WIDTH  = grc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_STEPS     = grc_pkg::MAX_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           op,
    input  logic [9:0]                     column,
    input  logic [5:0]                     cell_x,
    input  logic [5:0]                     cell_y,
    input  logic [3:0]                     cell_kind,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           done,
    output logic [9:0]                     column_out,
    output logic                           hit,
    output logic                           side,
    output logic [3:0]                     wall_kind,
    output logic [15:0]                    perp_dist,
    output logic signed [10:0]             wall_top,
    output logic signed [10:0]             wall_bottom,
    output logic [11:0]                    tex_u
);

    import grc_pkg::*;

    grc_cmd_t    cmd;
    grc_status_t status;

    assign cfg_ready = 1'b1;

    grc_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    grc_dp #(
        .MAP_SIZE      (MAP_SIZE),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_STEPS     (MAX_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .column      (column),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_kind   (cell_kind),
        .done        (done),
        .column_out  (column_out),
        .hit         (hit),
        .side        (side),
        .wall_kind   (wall_kind),
        .perp_dist   (perp_dist),
        .wall_top    (wall_top),
        .wall_bottom (wall_bottom),
        .tex_u       (tex_u)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (perp_dist == '0 && tex_u == '0 && wall_kind == '0))
        else $error("miss result carries non-zero fields");

endmodule

@@ tb/tb_grid_raycast_column.sv @@
// self-checking testbench of the dda column ray caster
module tb_grid_raycast_column;
    import grc_pkg::*;

    localparam int MAP_N       = 64;
    localparam int SCR_W       = 320;
    localparam int SCR_H       = 240;
    localparam int STEP_LIMIT  = 100;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 10;

    typedef struct {
        logic [9:0]         col;
        logic               hit;
        logic               side;
        logic [3:0]         kind;
        logic [15:0]        perp;
        logic signed [10:0] top;
        logic signed [10:0] bottom;
        logic [11:0]        tex;
    } column_res_t;

    typedef struct {
        logic        op;
        logic [9:0]  col;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [3:0]  kind;
        logic        typed;
        column_res_t res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               op = OP_WRITE;
    logic [9:0]         column = '0;
    logic [5:0]         cell_x = '0;
    logic [5:0]         cell_y = '0;
    logic [3:0]         cell_kind = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_POS_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic               done;
    logic [9:0]         column_out;
    logic               hit;
    logic               side;
    logic [3:0]         wall_kind;
    logic [15:0]        perp_dist;
    logic signed [10:0] wall_top;
    logic signed [10:0] wall_bottom;
    logic [11:0]        tex_u;

    logic [3:0]  grid_model [MAP_N*MAP_N];
    longint      m_pos_x, m_pos_y, m_dir_x, m_dir_y, m_plane_x, m_plane_y, m_eye;
    column_res_t pending_columns [$];
    stim_row_t   sent_rows [$];
    stim_row_t   directed [$];
    int          errors = 0;
    int          cycles = 0;
    int          n_casts = 0, n_hits = 0, n_writes = 0, n_cfg = 0;

    grid_raycast_column dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned cell_recip(longint r);
        longint unsigned a;
        a = (r < 0) ? -r : r;
        if (a == 0)
            return 64'd1 << 40;
        return (64'd1 << 30) / a;
    endfunction

    function automatic logic signed [10:0] sat_row(longint v);
        if (v < -1024) return -11'sd1024;
        if (v > 1023) return 11'sd1023;
        return v[10:0];
    endfunction

    function automatic column_res_t cast_column(logic [9:0] col);
        column_res_t     r;
        longint          cam, rx, ry, mx, my, wall, centre;
        longint unsigned dx, dy, sx, sy, perp, hgt, fx, fy;
        int              stx, sty;
        logic            sd, found;
        logic [3:0]      wk;
        r = '{default: '0};
        r.col = col;
        sd = 1'b0; found = 1'b0; wk = '0; perp = 0;
        cam = (2 * longint'(col) * 16384) / SCR_W - 16384;
        if (cam > 32767) cam = 32767;
        rx = m_dir_x + ((m_plane_x * cam) >>> 14);
        ry = m_dir_y + ((m_plane_y * cam) >>> 14);
        mx = m_pos_x >>> 8;
        my = m_pos_y >>> 8;
        dx = cell_recip(rx);
        dy = cell_recip(ry);
        fx = m_pos_x & 255;
        fy = m_pos_y & 255;
        stx = (rx < 0) ? -1 : 1;
        sty = (ry < 0) ? -1 : 1;
        sx = ((rx < 0 ? fx : 256 - fx) * dx) >> 8;
        sy = ((ry < 0 ? fy : 256 - fy) * dy) >> 8;
        for (int n = 0; n < STEP_LIMIT && !found; n++)
        begin
            if (sx < sy)
            begin
                sd = 1'b0; perp = sx; sx += dx; mx += stx;
            end
            else
            begin
                sd = 1'b1; perp = sy; sy += dy; my += sty;
            end
            if (mx >= 0 && mx < MAP_N && my >= 0 && my < MAP_N)
            begin
                wk = grid_model[mx*MAP_N + my];
                found = (wk != 0);
            end
        end
        if (found)
        begin
            if (perp > 64'hFFFFFF) perp = 64'hFFFFFF;
            hgt = (perp == 0) ? (64'd1 << 20) : ((64'(SCR_H) << 16) / perp);
            if (hgt > (64'd1 << 20)) hgt = 64'd1 << 20;
            centre = SCR_H / 2 - m_eye;
            wall = sd ? (m_pos_x * (64'sd1 << 22) + longint'(perp) * rx)
                      : (m_pos_y * (64'sd1 << 22) + longint'(perp) * ry);
            r.hit = 1'b1;
            r.side = sd;
            r.kind = wk;
            r.perp = perp[23:8];
            r.top = sat_row(centre - longint'(hgt / 2));
            r.bottom = sat_row(centre + longint'(hgt / 2));
            r.tex = wall[29:18];
        end
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // scoreboard: results, config transactions and accepted items
    always @(posedge clk)
    begin
        column_res_t want;
        stim_row_t   row;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
        if (done)
        begin
            if (pending_columns.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result for column %0d", $time, column_out);
            end
            else
            begin
                want = pending_columns.pop_front();
                if (hit) n_hits++;
                check_field("column_out", want.col, column_out);
                check_field("hit", want.hit, hit);
                check_field("side", want.side, side);
                check_field("wall_kind", want.kind, wall_kind);
                check_field("perp_dist", want.perp, perp_dist);
                check_field("wall_top", want.top, wall_top);
                check_field("wall_bottom", want.bottom, wall_bottom);
                check_field("tex_u", want.tex, tex_u);
            end
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            n_cfg++;
            case (cfg_index)
                CFG_POS_X:   m_pos_x = cfg_data[13:0];
                CFG_POS_Y:   m_pos_y = cfg_data[13:0];
                CFG_DIR_X:   m_dir_x = $signed(cfg_data);
                CFG_DIR_Y:   m_dir_y = $signed(cfg_data);
                CFG_PLANE_X: m_plane_x = $signed(cfg_data);
                CFG_PLANE_Y: m_plane_y = $signed(cfg_data);
                CFG_EYE:     m_eye = $signed(cfg_data[9:0]);
                default: ;
            endcase
        end
        if (rst_n && start && !busy)
        begin
            row = sent_rows.pop_front();
            if (op == OP_WRITE)
            begin
                n_writes++;
                grid_model[int'(cell_x)*MAP_N + int'(cell_y)] = cell_kind;
            end
            else
            begin
                n_casts++;
                pending_columns.push_back(row.typed ? row.res : cast_column(column));
            end
        end
    end

    task automatic send_item(stim_row_t row);
        sent_rows.push_back(row);
        start = 1'b1;
        op = row.op;
        column = row.col;
        cell_x = row.cx;
        cell_y = row.cy;
        cell_kind = row.kind;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending_columns.size() != 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic stim_row_t make_row(logic o, int c, int x, int y, int k,
                                           logic typed);
        stim_row_t r;
        r = '{op: o, col: 10'(c), cx: 6'(x), cy: 6'(y), kind: 4'(k), typed: typed,
              res: '{default: '0}};
        r.res.col = 10'(c);
        return r;
    endfunction

    function automatic int near_cell(longint pos);
        int c;
        c = int'(pos >>> 8) + $urandom_range(0, 12) - 6;
        return (c < 0) ? 0 : (c > MAP_N - 1) ? MAP_N - 1 : c;
    endfunction

    initial
    begin
        logic [15:0] regs [7];
        int          burst, gap, sel;
        stim_row_t   r;
        foreach (grid_model[i]) grid_model[i] = '0;
        m_pos_x = 0; m_pos_y = 0; m_dir_x = 16384; m_dir_y = 0;
        m_plane_x = 0; m_plane_y = 10813; m_eye = 0;

        // directed: empty map, clamped camera, zero ray component, then map writes and casts over them
        directed.push_back(make_row(OP_CAST, 0, 0, 0, 0, 1'b1));
        directed.push_back(make_row(OP_CAST, 1023, 0, 0, 0, 1'b1));
        directed.push_back(make_row(OP_CAST, 160, 0, 0, 0, 1'b1));
        directed.push_back(make_row(OP_WRITE, 0, 5, 0, 3, 1'b0));
        directed.push_back(make_row(OP_WRITE, 0, 63, 63, 15, 1'b0));
        directed.push_back(make_row(OP_WRITE, 0, 0, 0, 0, 1'b0));
        directed.push_back(make_row(OP_WRITE, 0, 4, 2, 9, 1'b0));
        directed.push_back(make_row(OP_WRITE, 0, 20, 63, 6, 1'b0));
        directed.push_back(make_row(OP_CAST, 160, 0, 0, 0, 1'b0));
        directed.push_back(make_row(OP_CAST, 1, 0, 0, 0, 1'b0));
        directed.push_back(make_row(OP_CAST, 320, 0, 0, 0, 1'b0));
        directed.push_back(make_row(OP_CAST, 240, 0, 0, 0, 1'b0));
        directed.push_back(make_row(OP_CAST, 100, 0, 0, 0, 1'b0));
        directed.push_back(make_row(OP_CAST, 1023, 0, 0, 0, 1'b0));
        directed.push_back(make_row(OP_WRITE, 0, 5, 0, 0, 1'b0));
        directed.push_back(make_row(OP_CAST, 160, 0, 0, 0, 1'b1));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        foreach (directed[i])
            send_item(directed[i]);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: regs = '{16'd8320, 16'd8320, 16'd16384, 16'd0, 16'd0, 16'd10813, 16'd0};
                1: regs = '{16'd256, 16'd384, 16'hC000, 16'd0, 16'd0, 16'd0, 16'd511};
                2: regs = '{16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                            16'hFE00};
                3: regs = '{16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0};
                default:
                begin
                    foreach (regs[i]) regs[i] = 16'($urandom_range(0, 65535));
                    regs[0] = 16'($urandom_range(1024, 15359)) | (regs[6] & 16'hC000);
                    regs[1] = 16'($urandom_range(1024, 15359));
                end
            endcase
            for (int i = 0; i < 7; i++)
                write_reg(cfg_idx_t'(i), regs[i]);
            // zero distance: wall just behind a gridline the ray starts on
            if (ph == 1)
                send_item(make_row(OP_WRITE, 0, 0, 1, 7, 1'b0));
            burst = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 30);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    if (gap != 0)
                    begin
                        start = 1'b0;
                        repeat (gap) @(negedge clk);
                    end
                end
                burst--;
                sel = $urandom_range(0, 99);
                if (sel < 35)
                    r = make_row(OP_WRITE, $urandom_range(0, 1023), near_cell(m_pos_x),
                                 near_cell(m_pos_y),
                                 ($urandom_range(0, 9) < 7) ? $urandom_range(1, 15) : 0,
                                 1'b0);
                else if (sel < 40)
                    r = make_row(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 63),
                                 $urandom_range(0, 63), $urandom_range(0, 15), 1'b0);
                else
                    r = make_row(OP_CAST,
                                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                             : $urandom_range(0, SCR_W),
                                 $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom_range(0, 15), 1'b0);
                send_item(r);
            end
            drain();
        end

        repeat (400) @(negedge clk);
        if (pending_columns.size() != 0)
        begin
            errors += pending_columns.size();
            $display("%0t: %0d expected results never came", $time, pending_columns.size());
        end
        $display("covered %0d casts (%0d hits), %0d map writes, %0d register writes",
                 n_casts, n_hits, n_writes, n_cfg);
        $display("over %0d view settings, %0d mismatches", NUM_PHASES + 1, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/grc_pkg.sv
sv/grc_ram.sv
sv/grc_div.sv
sv/grc_dp.sv
sv/grc_ctrl.sv
sv/grid_raycast_column.sv
tb/tb_grid_raycast_column.sv
